>>> rtl/wbs_pkg.sv
`default_nettype none

package wbs_pkg;

  localparam int MaxWords   = 16;
  localparam int MaxWordLen = 16;

  localparam int WordIdxW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int PosW     = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int LenW     = $clog2(MaxWordLen + 1);

  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActLoad  = 2'd1;
  localparam logic [1:0] ActText  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] word_slot;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic prefix_breakable;
    logic end_of_text;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/word_break_segmenter_core.sv
`default_nettype none

// Channel  | Direction | Handshake                | Payload
// in       | input     | in_valid_i / in_ready_o  | in_data_i  (wbs_pkg::in_item_t)
// out      | output    | out_valid_o / out_ready_i| out_data_o (wbs_pkg::out_item_t)
//
// Clear and load items produce no transfer on the out channel, and the input stays ready after them.
// After a text transfer the input stays not ready while the block scans the dictionary, drains
// the compare stage and loads the result: one dictionary row is read and compared per cycle.
// Reset is asynchronous and active low; the dictionary memory itself is not cleared.
// A stalled output holds the finished result, and the block waits before loading
// the next one.

module word_break_segmenter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wbs_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wbs_pkg::out_item_t  out_data_o
);
  import wbs_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StDone
  } state_e;

  state_e state_q;

  logic [7:0]          mem_q [MaxWords][MaxWordLen];
  logic [7:0]          rd_data_q [MaxWordLen];
  logic [LenW-1:0]     len_q [MaxWords];
  logic [7:0]          text_q [MaxWordLen];
  logic [MaxWordLen-1:0] brk_q;
  logic [WordIdxW-1:0] rd_idx_q;
  logic [WordIdxW-1:0] cmp_idx_q;
  logic                cmp_vld_q;
  logic                hit_q;
  logic                last_q;
  logic                out_valid_q;
  out_item_t           out_data_q;

  logic                in_fire;
  logic                can_load;
  logic                match;
  logic [LenW-1:0]     cur_len;
  logic [LenW-1:0]     len_m1;
  logic [PosW-1:0]     tidx;
  logic                hit_d;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign can_load    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    cur_len = len_q[cmp_idx_q];
    len_m1  = LenW'(cur_len - 1'b1);
    match   = (cur_len != '0) && brk_q[len_m1[PosW-1:0]];
    tidx    = '0;
    for (int j = 0; j < MaxWordLen; j++) begin
      tidx = PosW'(len_m1[PosW-1:0] - PosW'(j));
      if (LenW'(j) < cur_len) begin
        if (rd_data_q[j] != text_q[tidx]) begin
          match = 1'b0;
        end
      end
    end
    hit_d = hit_q || (cmp_vld_q && match);
  end

  // Word memory: one byte written per load item, one full row read per cycle.
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_data_i.action == ActLoad) &&
        (32'(in_data_i.word_slot) < MaxWords) &&
        (32'(in_data_i.char_position) < MaxWordLen)) begin
      mem_q[in_data_i.word_slot[WordIdxW-1:0]][in_data_i.char_position[PosW-1:0]]
        <= in_data_i.char_value;
    end
    rd_data_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      for (int w = 0; w < MaxWords; w++) begin
        len_q[w] <= '0;
      end
      for (int k = 0; k < MaxWordLen; k++) begin
        text_q[k] <= '0;
      end
      brk_q       <= MaxWordLen'(1);
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      cmp_idx_q <= rd_idx_q;
      cmp_vld_q <= (state_q == StScan);
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            unique case (in_data_i.action)
              ActClear: begin
                for (int w = 0; w < MaxWords; w++) begin
                  len_q[w] <= '0;
                end
              end
              ActLoad: begin
                if ((32'(in_data_i.word_slot) < MaxWords) &&
                    (32'(in_data_i.char_position) < MaxWordLen)) begin
                  len_q[in_data_i.word_slot[WordIdxW-1:0]] <= in_data_i.is_last ?
                    LenW'(32'(in_data_i.char_position) + 1) : '0;
                end
              end
              ActText: begin
                for (int k = MaxWordLen - 1; k > 0; k--) begin
                  text_q[k] <= text_q[k-1];
                end
                text_q[0] <= in_data_i.char_value;
                last_q    <= in_data_i.is_last;
                hit_q     <= 1'b0;
                rd_idx_q  <= '0;
                state_q   <= StScan;
              end
              default: begin
              end
            endcase
          end
        end
        StScan: begin
          hit_q <= hit_d;
          if (rd_idx_q == WordIdxW'(MaxWords - 1)) begin
            state_q <= StDrain;
          end else begin
            rd_idx_q <= WordIdxW'(rd_idx_q + 1'b1);
          end
        end
        StDrain: begin
          hit_q   <= hit_d;
          state_q <= StDone;
        end
        StDone: begin
          if (can_load) begin
            out_valid_q                 <= 1'b1;
            out_data_q.prefix_breakable <= hit_q;
            out_data_q.end_of_text      <= last_q;
            if (last_q) begin
              for (int k = 0; k < MaxWordLen; k++) begin
                text_q[k] <= '0;
              end
              brk_q <= MaxWordLen'(1);
            end else begin
              brk_q <= {brk_q[MaxWordLen-2:0], hit_q};
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_text_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.action == ActText)) |=> (state_q == StScan && rd_idx_q == '0))
    else $error("text transfer did not start a scan at word zero");

  a_cmp_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == StScan || state_q == StDrain))
    else $error("compare stage active outside a scan");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && can_load) |=> (state_q == StIdle && out_valid_q))
    else $error("finished result was not loaded into the output register");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && can_load && last_q) |=> (brk_q == MaxWordLen'(1)))
    else $error("end of text did not restart the boundary window");

endmodule

`default_nettype wire

>>> bench/word_break_segmenter_core_test.sv
`timescale 1ns / 100ps

module word_break_segmenter_core_test;
  import wbs_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int HoldCycles = 400;
  localparam int StuckLimit = 3000;
  localparam int PhaseItems = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  word_break_segmenter_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Dictionary and text window as the block should hold them.
  logic [7:0]            dict_char [MaxWords][MaxWordLen];
  logic [LenW-1:0]       dict_len [MaxWords];
  logic [7:0]            text_window [MaxWordLen];
  logic [MaxWordLen-1:0] boundary_ok;
  out_item_t             breakable_expected [$];

  // Dictionary as the stimulus will have left it once every queued item is applied.
  logic [7:0] plan_char [MaxWords][MaxWordLen];
  int         plan_len [MaxWords];
  bit         plan_written [MaxWords][MaxWordLen];
  in_item_t   pending_items [$];
  int         items_queued = 0;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int mismatches = 0;
  int results_checked = 0;
  int texts_ended = 0;
  int texts_breakable = 0;
  int action_count [4] = '{0, 0, 0, 0};

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 85) return 8'h61 + 8'($urandom_range(2));
    return 8'($urandom);
  endfunction

  task automatic apply_transfer(input in_item_t item);
    logic      hit;
    logic      same;
    out_item_t want;
    int        n;
    int        k;
    hit = 1'b0;
    case (item.action)
      ActClear: begin
        foreach (dict_len[s]) dict_len[s] = '0;
      end
      ActLoad: begin
        dict_char[item.word_slot][item.char_position] = item.char_value;
        dict_len[item.word_slot] = item.is_last ? LenW'(item.char_position) + LenW'(1) : '0;
      end
      ActText: begin
        for (k = MaxWordLen - 1; k > 0; k--) text_window[k] = text_window[k-1];
        text_window[0] = item.char_value;
        for (n = 0; n < MaxWords && !hit; n++) begin
          if (dict_len[n] != 0 && boundary_ok[dict_len[n] - 1]) begin
            same = 1'b1;
            for (k = 0; k < int'(dict_len[n]); k++) begin
              if (dict_char[n][int'(dict_len[n]) - 1 - k] != text_window[k]) same = 1'b0;
            end
            hit = same;
          end
        end
        boundary_ok = {boundary_ok[MaxWordLen-2:0], hit};
        want.prefix_breakable = hit;
        want.end_of_text = item.is_last;
        breakable_expected.push_back(want);
        if (item.is_last) begin
          foreach (text_window[b]) text_window[b] = '0;
          boundary_ok = MaxWordLen'(1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic enqueue(input logic [1:0] act, input logic [3:0] slot, input logic [3:0] pos,
                         input logic [7:0] ch, input logic last);
    in_item_t item;
    item.action = act;
    item.word_slot = slot;
    item.char_position = pos;
    item.char_value = ch;
    item.is_last = last;
    pending_items.push_back(item);
    if (act != ActUnused) items_queued++;
    if (act == ActClear) begin
      foreach (plan_len[s]) plan_len[s] = 0;
    end
    if (act == ActLoad) begin
      plan_char[slot][pos] = ch;
      plan_written[slot][pos] = 1'b1;
      plan_len[slot] = last ? int'(pos) + 1 : 0;
    end
  endtask

  // Text built mostly from words now in the dictionary, with some stray bytes between them.
  task automatic queue_sentence();
    logic [7:0] bytes_q [$];
    int         live [$];
    int         pieces;
    int         p;
    int         s;
    int         j;
    for (s = 0; s < MaxWords; s++) begin
      if (plan_len[s] != 0) live.push_back(s);
    end
    pieces = $urandom_range(5, 1);
    for (p = 0; p < pieces; p++) begin
      if (live.size() != 0 && $urandom_range(99) < 85) begin
        s = live[$urandom_range(live.size() - 1)];
        for (j = 0; j < plan_len[s]; j++) bytes_q.push_back(plan_char[s][j]);
      end else begin
        repeat ($urandom_range(3, 1)) bytes_q.push_back(rand_char());
      end
    end
    for (j = 0; j < bytes_q.size(); j++) begin
      enqueue(ActText, 4'($urandom), 4'($urandom), bytes_q[j],
              j == bytes_q.size() - 1 && $urandom_range(9) != 0);
    end
  endtask

  task automatic queue_random_event();
    int   pick;
    int   slot;
    int   len;
    int   pos;
    int   j;
    logic last;
    pick = $urandom_range(99);
    slot = $urandom_range(MaxWords - 1);
    if (pick < 3) begin
      enqueue(ActClear, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
    end else if (pick < 5) begin
      enqueue(ActUnused, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
    end else if (pick < 25) begin
      j = $urandom_range(99);
      len = (j < 80) ? $urandom_range(4, 1) :
            (j < 95) ? $urandom_range(10, 5) : $urandom_range(MaxWordLen, 11);
      for (pos = 0; pos < len; pos++) begin
        enqueue(ActLoad, 4'(slot), 4'(pos), rand_char(), pos == len - 1);
      end
    end else if (pick < 32) begin
      pos = $urandom_range(MaxWordLen - 1);
      last = 1'($urandom);
      for (j = 0; j < pos; j++) begin
        if (!plan_written[slot][j]) last = 1'b0;
      end
      enqueue(ActLoad, 4'(slot), 4'(pos), rand_char(), last);
    end else begin
      queue_sentence();
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || breakable_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (MaxWords + 4) @(negedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input bit squeeze);
    int target;
    idle_pct = idle;
    stall_pct = stall;
    target = items_queued + PhaseItems;
    while (items_queued < target) queue_random_event();
    if (squeeze) hold_requests++;
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        action_count[in_data.action]++;
        apply_transfer(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_started < hold_requests) begin
        holds_started <= holds_started + 1;
        hold_left <= HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (breakable_expected.size() == 0) begin
        $error("Result transfer arrived with no text byte pending.");
        mismatches++;
      end else begin
        results_checked++;
        if (breakable_expected[0].end_of_text) begin
          texts_ended++;
          if (breakable_expected[0].prefix_breakable) texts_breakable++;
        end
        if (out_data.prefix_breakable !== breakable_expected[0].prefix_breakable) begin
          $error("prefix_breakable: expected %0b, actual %0b",
                 breakable_expected[0].prefix_breakable, out_data.prefix_breakable);
          mismatches++;
        end
        if (out_data.end_of_text !== breakable_expected[0].end_of_text) begin
          $error("end_of_text: expected %0b, actual %0b",
                 breakable_expected[0].end_of_text, out_data.end_of_text);
          mismatches++;
        end
        void'(breakable_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (dict_len[s]) dict_len[s] = '0;
    foreach (text_window[b]) text_window[b] = '0;
    boundary_ok = MaxWordLen'(1);
    foreach (plan_len[s]) plan_len[s] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    enqueue(ActText, 4'd0, 4'd0, 8'h00, 1'b1);
    enqueue(ActLoad, 4'd0, 4'd0, "a", 1'b0);
    enqueue(ActLoad, 4'd0, 4'd1, "b", 1'b1);
    enqueue(ActText, 4'd15, 4'd15, "a", 1'b0);
    enqueue(ActText, 4'd0, 4'd0, "b", 1'b1);
    enqueue(ActLoad, 4'd15, 4'd15, 8'hff, 1'b0);
    enqueue(ActLoad, 4'd15, 4'd0, 8'hff, 1'b1);
    enqueue(ActText, 4'd0, 4'd0, 8'hff, 1'b1);
    enqueue(ActText, 4'd0, 4'd0, "x", 1'b0);
    enqueue(ActText, 4'd0, 4'd0, "a", 1'b0);
    enqueue(ActText, 4'd0, 4'd0, "b", 1'b1);
    // The first byte of slot 0 is kept from the earlier word.
    enqueue(ActLoad, 4'd0, 4'd1, "z", 1'b1);
    enqueue(ActText, 4'd0, 4'd0, "a", 1'b0);
    enqueue(ActText, 4'd0, 4'd0, "z", 1'b1);
    enqueue(ActLoad, 4'd0, 4'd0, "a", 1'b0);
    enqueue(ActText, 4'd0, 4'd0, "a", 1'b0);
    enqueue(ActText, 4'd0, 4'd0, "z", 1'b1);
    enqueue(ActUnused, 4'd15, 4'd15, 8'hff, 1'b1);
    enqueue(ActClear, 4'd15, 4'd15, 8'hff, 1'b1);
    enqueue(ActText, 4'd15, 4'd15, 8'hff, 1'b1);
    drain();

    run_phase(0, 0, 1'b0);
    run_phase(77, 0, 1'b0);
    run_phase(0, 77, 1'b0);
    run_phase(8, 8, 1'b0);
    run_phase(0, 0, 1'b1);

    if (breakable_expected.size() != 0) begin
      $error("%0d expected results never arrived.", breakable_expected.size());
      mismatches++;
    end
    $display("Sent %0d text bytes, %0d dictionary loads, %0d clears and %0d unused codes.",
             action_count[ActText], action_count[ActLoad], action_count[ActClear],
             action_count[ActUnused]);
    $display("Checked %0d results; %0d texts ended, %0d of them breakable.",
             results_checked, texts_ended, texts_breakable);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
